>>> hdl/csp_pkg.sv
// Shared types and constants for the curtain stepper position controller.
// No dependencies; imported by the config registers, step logic and top level.
`default_nettype none

package csp_pkg;

  typedef enum logic [2:0] {
    MODE_STOPPED = 3'd0,
    MODE_OPENING = 3'd1,
    MODE_OPEN    = 3'd2,
    MODE_CLOSING = 3'd3,
    MODE_CLOSED  = 3'd4,
    MODE_CALIB   = 3'd5,
    MODE_PENDING = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_OPEN  = 3'd1,
    OP_STOP  = 3'd2,
    OP_CLOSE = 3'd3,
    OP_TICK  = 3'd4
  } op_t;

  localparam logic [1:0] CFG_CLOSE_LIMIT = 2'd0;
  localparam logic [1:0] CFG_CHUNK_STEPS = 2'd1;
  localparam logic [1:0] CFG_A_OPEN_LVL  = 2'd2;
  localparam logic [1:0] CFG_B_OPEN_LVL  = 2'd3;

  localparam int CFG_DATA_BITS = 16;
  localparam int CHUNK_BITS    = 10;

  localparam logic [15:0]           CLOSE_LIMIT_RST = 16'd4096;
  localparam logic [CHUNK_BITS-1:0] CHUNK_STEPS_RST = 10'd64;

  localparam int SOFT_STOP_LIMIT = -500;

  typedef struct packed {
    logic [15:0]           close_limit;
    logic [CHUNK_BITS-1:0] chunk_steps;
    logic                  a_open_lvl;
    logic                  b_open_lvl;
  } cfg_t;

  typedef struct packed {
    mode_t      cur_mode;
    mode_t      req_mode;
    logic       home;
    logic       enable;
    logic [1:0] dir;
  } state_t;

  typedef struct packed {
    logic                  announce;
    logic [CHUNK_BITS-1:0] pulses;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/csp_cfg_regs.sv
// Configuration register file: close limit, chunk size, open direction levels.
// Depends on csp_pkg.
`default_nettype none

module csp_cfg_regs
  import csp_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output cfg_t                          cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.close_limit <= CLOSE_LIMIT_RST;
      cfg_r.chunk_steps <= CHUNK_STEPS_RST;
      cfg_r.a_open_lvl  <= 1'b1;
      cfg_r.b_open_lvl  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLOSE_LIMIT: cfg_r.close_limit <= cfg_wdata;
        CFG_CHUNK_STEPS: cfg_r.chunk_steps <= cfg_wdata[CHUNK_BITS-1:0];
        CFG_A_OPEN_LVL:  cfg_r.a_open_lvl  <= cfg_wdata[0];
        CFG_B_OPEN_LVL:  cfg_r.b_open_lvl  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> hdl/csp_step_logic.sv
// Next-state logic for one item: commands, homing, mode transitions, one chunk
// of pulses and saturating position update. Depends on csp_pkg.
`default_nettype none

module csp_step_logic
  import csp_pkg::*;
#(
  parameter int POSITION_BITS = 24
) (
  input  cfg_t                             cfg,
  input  state_t                           st,
  input  wire logic signed [POSITION_BITS-1:0] pos,
  input  wire logic [2:0]                  opcode,
  input  wire logic                        end_switch,
  output state_t                           st_nxt,
  output logic signed [POSITION_BITS-1:0]  pos_nxt,
  output result_t                          res
);

  localparam int P = POSITION_BITS;
  localparam logic signed [P-1:0] POS_MAX  = {1'b0, {(P-1){1'b1}}};
  localparam logic signed [P-1:0] POS_MIN  = {1'b1, {(P-1){1'b0}}};
  localparam logic signed [P-1:0] SOFT_LIM = P'(SOFT_STOP_LIMIT);

  logic              moving;
  logic              toward_open;
  logic signed [P:0] sum_w;
  logic signed [P:0] step_w;
  logic signed [P-1:0] np;
  mode_t             c;
  mode_t             r;

  always_comb begin
    st_nxt       = st;
    pos_nxt      = pos;
    res.announce = 1'b0;
    res.pulses   = '0;
    moving       = 1'b0;
    toward_open  = 1'b0;
    c            = st.cur_mode;
    r            = st.req_mode;
    step_w       = $signed({{(P+1-CHUNK_BITS){1'b0}}, cfg.chunk_steps});
    sum_w        = '0;
    np           = pos;

    case (op_t'(opcode))
      OP_START: begin
        st_nxt.enable = 1'b0;
        if (!end_switch) st_nxt.req_mode = MODE_CALIB;
        else             st_nxt.home     = 1'b1;
      end
      OP_OPEN:  st_nxt.req_mode = MODE_OPENING;
      OP_STOP:  st_nxt.req_mode = MODE_STOPPED;
      OP_CLOSE: st_nxt.req_mode = MODE_CLOSING;
      OP_TICK: begin
        if (st.home) begin
          pos_nxt         = '0;
          st_nxt.home     = 1'b0;
          st_nxt.cur_mode = MODE_OPEN;
          st_nxt.req_mode = MODE_OPEN;
          res.announce    = 1'b1;
          c = MODE_OPEN;
          r = MODE_OPEN;
        end

        if (((c == MODE_CLOSING || c == MODE_CLOSED || c == MODE_STOPPED) &&
             r == MODE_OPENING) ||
            ((c == MODE_OPENING || c == MODE_OPEN || c == MODE_STOPPED) &&
             r == MODE_CLOSING) ||
            r == MODE_CALIB) begin
          st_nxt.cur_mode = r;
          st_nxt.req_mode = MODE_PENDING;
          st_nxt.enable   = 1'b1;
          if (r != MODE_CALIB) res.announce = 1'b1;
          c = r;
        end else if ((c == MODE_OPENING && r == MODE_OPEN) ||
                     (c == MODE_CLOSING && r == MODE_CLOSED) ||
                     r == MODE_STOPPED) begin
          st_nxt.cur_mode = r;
          st_nxt.req_mode = MODE_PENDING;
          st_nxt.enable   = 1'b0;
          res.announce    = 1'b1;
          c = r;
        end

        moving      = (c == MODE_CLOSING || c == MODE_OPENING || c == MODE_CALIB);
        toward_open = (c == MODE_OPENING || c == MODE_CALIB);
        if (moving) begin
          st_nxt.dir[0] = toward_open ? cfg.a_open_lvl : ~cfg.a_open_lvl;
          st_nxt.dir[1] = toward_open ? cfg.b_open_lvl : ~cfg.b_open_lvl;
          if (end_switch && toward_open) begin
            // end stop met: no pulses, home on the next tick
            st_nxt.home = 1'b1;
          end else begin
            // chunk add, from the position as homing leaves it
            sum_w = $signed({pos_nxt[P-1], pos_nxt});
            sum_w = toward_open ? (sum_w - step_w) : (sum_w + step_w);
            if (sum_w[P] != sum_w[P-1]) np = sum_w[P] ? POS_MIN : POS_MAX;
            else                        np = sum_w[P-1:0];
            res.pulses = cfg.chunk_steps;
            pos_nxt    = np;
            if ($signed({np[P-1], np}) >=
                $signed({{(P-15){1'b0}}, cfg.close_limit}))
              st_nxt.req_mode = MODE_CLOSED;
            if (np < SOFT_LIM && c != MODE_CALIB)
              st_nxt.home = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/curtain_stepper_position_controller_top.sv
// Top level of the curtain stepper position controller: input register, state
// registers, result register. Depends on csp_pkg, csp_cfg_regs, csp_step_logic.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_stall, in_opcode, in_end_switch | item in
//   out     | out_valid, out_stall, out_motion_state .. out_position | item out
//   cfg     | cfg_we, cfg_index, cfg_wdata            | write only
//
// One item per cycle sustained while out_stall stays low; the result passes the
// input register, then the result register, before it is valid on out and can be
// taken (state updates as the item passes).
// Synchronous active-low reset returns modes to stopped, position to zero and
// the config registers to their defaults. A stall on out holds the result and
// backs up into in_stall only when both registers are occupied.
`default_nettype none

module curtain_stepper_position_controller_top
  import csp_pkg::*;
#(
  parameter int POSITION_BITS = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [2:0]               in_opcode,
  input  wire logic                     in_end_switch,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [2:0]                    out_motion_state,
  output logic                          out_announce,
  output logic                          out_motors_on,
  output logic                          out_dir_a,
  output logic                          out_dir_b,
  output logic [CHUNK_BITS-1:0]         out_pulses,
  output logic signed [POSITION_BITS-1:0] out_position,
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  cfg_t    cfg;
  state_t  st_r, st_nxt;
  result_t res;
  logic signed [POSITION_BITS-1:0] pos_r, pos_nxt;

  logic       in_valid_r;
  logic [2:0] opcode_r;
  logic       end_switch_r;
  logic       out_valid_r;
  logic       adv, fire, in_acc;

  result_t                         res_r;
  state_t                          ost_r;
  logic signed [POSITION_BITS-1:0] opos_r;

  csp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  csp_step_logic #(
    .POSITION_BITS (POSITION_BITS)
  ) u_step (
    .cfg        (cfg),
    .st         (st_r),
    .pos        (pos_r),
    .opcode     (opcode_r),
    .end_switch (end_switch_r),
    .st_nxt     (st_nxt),
    .pos_nxt    (pos_nxt),
    .res        (res)
  );

  assign adv      = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && adv;
  assign in_stall = in_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      st_r.cur_mode   <= MODE_STOPPED;
      st_r.req_mode   <= MODE_STOPPED;
      st_r.home       <= 1'b0;
      st_r.enable     <= 1'b0;
      st_r.dir        <= 2'b00;
      pos_r           <= '0;
    end else begin
      if (in_acc)    in_valid_r <= 1'b1;
      else if (fire) in_valid_r <= 1'b0;

      if (fire) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
        pos_r       <= pos_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      opcode_r     <= in_opcode;
      end_switch_r <= in_end_switch;
    end
    if (fire) begin
      res_r  <= res;
      ost_r  <= st_nxt;
      opos_r <= pos_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_motion_state = ost_r.cur_mode;
  assign out_announce     = res_r.announce;
  assign out_motors_on    = ost_r.enable;
  assign out_dir_a        = ost_r.dir[0];
  assign out_dir_b        = ost_r.dir[1];
  assign out_pulses       = res_r.pulses;
  assign out_position     = opos_r;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result side is free");

  a_fire_shows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("item passed the input register but no result shown");

  a_pulse_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pulses != '0) |->
      (out_motion_state == MODE_OPENING || out_motion_state == MODE_CLOSING ||
       out_motion_state == MODE_CALIB))
    else $error("pulses issued outside a moving mode");

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for curtain_stepper_position_controller_top: directed and
// random command/tick items, results checked against a built-in controller model.
// Depends on csp_pkg and the controller RTL.

module testbench;
  import csp_pkg::*;

  localparam int     POS_BITS = 24;
  localparam longint POS_MAX  = (longint'(1) << (POS_BITS - 1)) - 1;
  localparam longint POS_MIN  = -POS_MAX - 1;

  // opcodes the block must ignore
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  typedef struct {
    logic [2:0]            mode;
    logic                  announce;
    logic                  motors_on;
    logic                  dir_a;
    logic                  dir_b;
    logic [CHUNK_BITS-1:0] pulses;
    logic [POS_BITS-1:0]   position;
  } status_t;

  class curtain_scoreboard;
    status_t awaiting[$];
    int      errors;
    int      checked;
    mode_t   cur_mode;
    mode_t   req_mode;
    bit      home_flag;
    bit      drivers_on;
    bit [1:0] dir_lvl;
    longint  step_pos;
    int      close_limit;
    int      chunk;
    bit      a_open;
    bit      b_open;

    function new();
      close_limit = int'(CLOSE_LIMIT_RST);
      chunk       = int'(CHUNK_STEPS_RST);
      a_open      = 1'b1;
      b_open      = 1'b0;
      cur_mode    = MODE_STOPPED;
      req_mode    = MODE_STOPPED;
      home_flag   = 1'b0;
      drivers_on  = 1'b0;
      dir_lvl     = 2'b00;
      step_pos    = 0;
      errors      = 0;
      checked     = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_CLOSE_LIMIT: close_limit = int'(val);
        CFG_CHUNK_STEPS: chunk = int'(val[CHUNK_BITS-1:0]);
        CFG_A_OPEN_LVL:  a_open = val[0];
        CFG_B_OPEN_LVL:  b_open = val[0];
        default: ;
      endcase
    endfunction

    function int outstanding();
      return awaiting.size();
    endfunction

    function void tick_motion(bit sw, output bit ann, output bit [CHUNK_BITS-1:0] pul);
      mode_t  c;
      mode_t  r;
      bit     toward_open;
      longint np;
      ann = 1'b0;
      pul = '0;
      if (home_flag) begin
        step_pos  = 0;
        home_flag = 1'b0;
        cur_mode  = MODE_OPEN;
        req_mode  = MODE_OPEN;
        ann       = 1'b1;
      end
      c = cur_mode;
      r = req_mode;
      if (((c == MODE_CLOSING || c == MODE_CLOSED || c == MODE_STOPPED) && r == MODE_OPENING) ||
          ((c == MODE_OPENING || c == MODE_OPEN || c == MODE_STOPPED) && r == MODE_CLOSING) ||
          r == MODE_CALIB) begin
        cur_mode   = r;
        req_mode   = MODE_PENDING;
        drivers_on = 1'b1;
        if (r != MODE_CALIB) ann = 1'b1;
      end else if ((c == MODE_OPENING && r == MODE_OPEN) ||
                   (c == MODE_CLOSING && r == MODE_CLOSED) || r == MODE_STOPPED) begin
        cur_mode   = r;
        req_mode   = MODE_PENDING;
        drivers_on = 1'b0;
        ann        = 1'b1;
      end
      c = cur_mode;
      if (c == MODE_CLOSING || c == MODE_OPENING || c == MODE_CALIB) begin
        toward_open = (c == MODE_OPENING) || (c == MODE_CALIB);
        dir_lvl = {toward_open ? b_open : ~b_open, toward_open ? a_open : ~a_open};
        // end stop is only honored when heading toward open
        if (sw && toward_open) begin
          home_flag = 1'b1;
          return;
        end
        pul = chunk[CHUNK_BITS-1:0];
        np  = step_pos + (toward_open ? -longint'(chunk) : longint'(chunk));
        if (np > POS_MAX) np = POS_MAX;
        if (np < POS_MIN) np = POS_MIN;
        step_pos = np;
        if (step_pos >= close_limit) req_mode = MODE_CLOSED;
        if (step_pos < SOFT_STOP_LIMIT && c != MODE_CALIB) home_flag = 1'b1;
      end
    endfunction

    function void note_input(logic [2:0] op, logic sw);
      status_t s;
      bit      ann;
      bit [CHUNK_BITS-1:0] pul;
      ann = 1'b0;
      pul = '0;
      case (op)
        OP_START: begin
          drivers_on = 1'b0;
          if (!sw) req_mode = MODE_CALIB;
          else home_flag = 1'b1;
        end
        OP_OPEN:  req_mode = MODE_OPENING;
        OP_STOP:  req_mode = MODE_STOPPED;
        OP_CLOSE: req_mode = MODE_CLOSING;
        OP_TICK:  tick_motion(sw, ann, pul);
        default: ;
      endcase
      s.mode      = cur_mode;
      s.announce  = ann;
      s.motors_on = drivers_on;
      s.dir_a     = dir_lvl[0];
      s.dir_b     = dir_lvl[1];
      s.pulses    = pul;
      s.position  = step_pos[POS_BITS-1:0];
      awaiting.push_back(s);
    endfunction

    task report(string msg);
      if (errors < 100) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(status_t got);
      status_t want;
      checked++;
      if (awaiting.size() == 0) begin
        report($sformatf("result %0d arrived with no item outstanding", checked));
        return;
      end
      want = awaiting.pop_front();
      if (got.mode !== want.mode)
        report($sformatf("result %0d motion_state %0d, expected %0d", checked, got.mode,
                         want.mode));
      if (got.announce !== want.announce)
        report($sformatf("result %0d announce %b, expected %b", checked, got.announce,
                         want.announce));
      if (got.motors_on !== want.motors_on)
        report($sformatf("result %0d motors_on %b, expected %b", checked, got.motors_on,
                         want.motors_on));
      if (got.dir_a !== want.dir_a)
        report($sformatf("result %0d dir_a %b, expected %b", checked, got.dir_a, want.dir_a));
      if (got.dir_b !== want.dir_b)
        report($sformatf("result %0d dir_b %b, expected %b", checked, got.dir_b, want.dir_b));
      if (got.pulses !== want.pulses)
        report($sformatf("result %0d pulses %0d, expected %0d", checked, got.pulses,
                         want.pulses));
      if (got.position !== want.position)
        report($sformatf("result %0d position %h, expected %h", checked, got.position,
                         want.position));
    endtask

    task finish_check();
      if (awaiting.size() != 0)
        report($sformatf("%0d results never arrived", awaiting.size()));
    endtask
  endclass

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic [2:0]            in_opcode     = OP_TICK;
  logic                  in_end_switch = 1'b0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic [2:0]            out_motion_state;
  logic                  out_announce;
  logic                  out_motors_on;
  logic                  out_dir_a;
  logic                  out_dir_b;
  logic [CHUNK_BITS-1:0] out_pulses;
  logic signed [POS_BITS-1:0] out_position;
  logic                  cfg_we        = 1'b0;
  logic [1:0]            cfg_index     = CFG_CLOSE_LIMIT;
  logic [CFG_DATA_BITS-1:0] cfg_wdata  = '0;

  curtain_scoreboard tracker;
  bit steady = 1'b0;   // no gaps or stalls while set
  int items_sent = 0;
  int settings_used = 0;

  curtain_stepper_position_controller_top #(.POSITION_BITS(POS_BITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_end_switch(in_end_switch),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_motion_state(out_motion_state), .out_announce(out_announce),
    .out_motors_on(out_motors_on), .out_dir_a(out_dir_a), .out_dir_b(out_dir_b),
    .out_pulses(out_pulses), .out_position(out_position),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check what is taken at this edge, then pick the next stall
  always @(posedge clk) begin
    status_t got;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.mode      = out_motion_state;
      got.announce  = out_announce;
      got.motors_on = out_motors_on;
      got.dir_a     = out_dir_a;
      got.dir_b     = out_dir_b;
      got.pulses    = out_pulses;
      got.position  = out_position;
      tracker.check_result(got);
    end
    out_stall <= !steady && ($urandom_range(99) < 38);
  end

  task automatic send_item(logic [2:0] op, logic sw);
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_end_switch <= sw;
    do @(posedge clk); while (in_stall);
    tracker.note_input(op, sw);
    items_sent++;
    if (!steady && $urandom_range(99) < 38) begin
      in_valid      <= 1'b0;
      in_opcode     <= 3'($urandom);
      in_end_switch <= 1'($urandom);
      do @(posedge clk); while ($urandom_range(99) < 38);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // writes all four registers; unused upper data bits carry noise
  task automatic configure(logic [15:0] limit, logic [CHUNK_BITS-1:0] steps,
                           logic a_lvl, logic b_lvl);
    logic [15:0] word [4];
    logic [1:0]  idx  [4];
    word[0] = limit;
    word[1] = 16'($urandom);
    word[1][CHUNK_BITS-1:0] = steps;
    word[2] = 16'($urandom);
    word[2][0] = a_lvl;
    word[3] = 16'($urandom);
    word[3][0] = b_lvl;
    idx[0] = CFG_CLOSE_LIMIT;
    idx[1] = CFG_CHUNK_STEPS;
    idx[2] = CFG_A_OPEN_LVL;
    idx[3] = CFG_B_OPEN_LVL;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= word[i];
      @(posedge clk);
      tracker.set_reg(idx[i], word[i]);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // mostly a command followed by a run of ticks, plus some loose noise
  task automatic random_phase(int quota);
    int counted;
    int burst;
    logic [2:0] cmd;
    counted = 0;
    while (counted < quota) begin
      if ($urandom_range(99) < 85) begin
        case ($urandom_range(9))
          0, 1, 2: cmd = OP_OPEN;
          3, 4, 5: cmd = OP_CLOSE;
          6, 7:    cmd = OP_STOP;
          default: cmd = OP_START;
        endcase
        send_item(cmd, (cmd == OP_START) ? ($urandom_range(3) == 0) :
                                           1'($urandom_range(1)));
        burst = $urandom_range(1, 12);
        repeat (burst) send_item(OP_TICK, $urandom_range(99) < 8);
        counted += burst + 1;
      end else begin
        cmd = 3'($urandom_range(7));
        send_item(cmd, 1'($urandom_range(1)));
        if (cmd <= OP_TICK) counted++;
      end
    end
    settle();
  endtask

  initial begin
    tracker = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset register values
    send_item(OP_TICK, 1'b0);
    send_item(OP_SPARE_A, 1'b1);
    send_item(OP_SPARE_B, 1'b0);
    send_item(OP_SPARE_C, 1'b1);
    send_item(OP_CLOSE, 1'b1);
    send_item(OP_TICK, 1'b1);     // end stop ignored while closing
    send_item(OP_OPEN, 1'b0);
    send_item(OP_TICK, 1'b0);
    send_item(OP_TICK, 1'b1);     // end stop while opening: no pulses
    send_item(OP_TICK, 1'b0);     // homes to open
    send_item(OP_CLOSE, 1'b0);
    send_item(OP_TICK, 1'b0);
    send_item(OP_STOP, 1'b0);
    send_item(OP_TICK, 1'b0);
    send_item(OP_START, 1'b0);    // request calibration
    send_item(OP_TICK, 1'b0);
    send_item(OP_TICK, 1'b0);
    send_item(OP_TICK, 1'b1);
    send_item(OP_TICK, 1'b0);
    send_item(OP_START, 1'b1);
    send_item(OP_OPEN, 1'b0);
    send_item(OP_TICK, 1'b0);
    send_item(OP_STOP, 1'b1);
    send_item(OP_TICK, 1'b0);
    settle();

    configure(16'd300, 10'd37, 1'b0, 1'b1);
    random_phase(100);
    steady = 1'b1;
    configure(16'd0, 10'd1023, 1'b1, 1'b1);
    random_phase(100);
    steady = 1'b0;
    configure(16'd0, 10'd0, 1'b0, 1'b0);
    random_phase(100);
    configure(16'hFFFF, 10'd5, 1'b1, 1'b0);
    random_phase(100);
    configure(16'd120, 10'd1, 1'b0, 1'b1);
    random_phase(100);
    configure(16'($urandom_range(1500)), 10'($urandom_range(1, 300)),
              1'($urandom_range(1)), 1'($urandom_range(1)));
    random_phase(100);

    tracker.finish_check();
    $display("run covered %0d items and %0d results over %0d register settings",
             items_sent, tracker.checked, settings_used);
    $display("including calibration, homing, end stop, zero chunk and spare opcodes");
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
